### src/frame_slot_handoff_manager_core_macros.svh
// ----------------------------------------------------------------------------
// Frame slot handoff manager assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef FRAME_SLOT_HANDOFF_MANAGER_CORE_MACROS_SVH
`define FRAME_SLOT_HANDOFF_MANAGER_CORE_MACROS_SVH

// same-cycle implication, quiet while in reset
`define FSHM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame slot handoff manager: assertion failed");

// next-cycle implication, quiet while in reset
`define FSHM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame slot handoff manager: assertion failed");

`endif

### src/fshm_pkg.sv
// ----------------------------------------------------------------------------
// Frame slot handoff manager package
// Phase and request codes, field widths and stream packing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package fshm_pkg;

  localparam int SLOT_COUNT_DEFAULT = 2;

  localparam int OPCODE_W   = 3;
  localparam int SLOT_IN_W  = 8;
  localparam int FRAME_W    = 32;
  localparam int STATUS_W   = 1;
  localparam int SLOT_OUT_W = 4;

  localparam int IN_FIELDS_W  = OPCODE_W + SLOT_IN_W + FRAME_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATUS_W + SLOT_OUT_W + FRAME_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic [1:0]          phase_t;
  typedef logic [OPCODE_W-1:0] opcode_t;

  localparam phase_t PH_EMPTY   = 2'd0;
  localparam phase_t PH_WRITING = 2'd1;
  localparam phase_t PH_READY   = 2'd2;
  localparam phase_t PH_READING = 2'd3;

  localparam opcode_t OP_ACQ_WRITE = 3'd0;
  localparam opcode_t OP_PUBLISH   = 3'd1;
  localparam opcode_t OP_CANCEL    = 3'd2;
  localparam opcode_t OP_ACQ_READ  = 3'd3;
  localparam opcode_t OP_RELEASE   = 3'd4;

  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_REFUSED = 1'b1;

endpackage

`default_nettype wire

### src/frame_slot_handoff_manager_core.sv
// ----------------------------------------------------------------------------
// Frame slot handoff manager core
// Tracks ownership of frame slots passed from one producer to one consumer.
// ----------------------------------------------------------------------------
// Each request item gets exactly one result item. The block takes one item
// per cycle: an item is captured in the input register, executed against the
// slot table while it sits there (phase lanes, a pairwise minimum tree over
// the ready slots and the write pointer update), and its result lands in the
// output register. The slot table update in the execute stage is the loop
// that sets the rate. Backpressure on the result side stalls the input only
// once both registers are full.
`default_nettype none

module frame_slot_handoff_manager_core #(
  parameter int SLOT_COUNT = fshm_pkg::SLOT_COUNT_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // opcode[2:0], slot[10:3], frame_number[42:11], zero fill
  input  wire logic [fshm_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // status[0], slot_out[4:1], frame_out[36:5], zero fill
  output logic [fshm_pkg::OUT_TDATA_W-1:0]      m_tdata
);
  import fshm_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int LEVELS = SLOT_W;
  localparam int PAD    = 1 << LEVELS;

  logic                 in_valid;
  opcode_t              in_op;
  logic [SLOT_IN_W-1:0] in_slot;
  logic [FRAME_W-1:0]   in_frame;
  logic                 advance;

  phase_t               phase      [SLOT_COUNT];
  phase_t               phase_next [SLOT_COUNT];
  logic [FRAME_W-1:0]   frame_num  [SLOT_COUNT];
  logic [SLOT_W-1:0]    wp;
  logic [SLOT_W-1:0]    wp_next;
  logic                 frame_we;

  logic [SLOT_COUNT-1:0] sel;
  logic [SLOT_COUNT-1:0] wp_sel;
  logic [SLOT_COUNT-1:0] best_sel;
  logic [SLOT_COUNT-1:0] empty_mask;
  logic [SLOT_COUNT-1:0] writing_mask;
  logic [SLOT_COUNT-1:0] reading_mask;
  logic [PAD-1:0]        ready_pad;
  logic                  slot_ok;
  logic                  sel_writing;
  logic                  sel_reading;
  logic                  wp_empty;
  logic [SLOT_W-1:0]     slot_idx;

  logic                  lv_valid [LEVELS+1][PAD];
  logic [FRAME_W-1:0]    lv_frame [LEVELS+1][PAD];
  logic [SLOT_W-1:0]     lv_idx   [LEVELS+1][PAD];
  logic                  best_valid;
  logic [FRAME_W-1:0]    best_frame;
  logic [SLOT_W-1:0]     best_idx;

  logic                  res_status;
  logic [SLOT_OUT_W-1:0] res_slot;
  logic [FRAME_W-1:0]    res_frame;

  assign s_tready = !in_valid || !m_tvalid || m_tready;
  assign advance  = in_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op    <= s_tdata[OPCODE_W-1:0];
      in_slot  <= s_tdata[OPCODE_W +: SLOT_IN_W];
      in_frame <= s_tdata[OPCODE_W+SLOT_IN_W +: FRAME_W];
    end
  end

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      sel[i]          = (in_slot == SLOT_IN_W'(i));
      wp_sel[i]       = (wp == SLOT_W'(i));
      best_sel[i]     = (best_idx == SLOT_W'(i));
      empty_mask[i]   = (phase[i] == PH_EMPTY);
      writing_mask[i] = (phase[i] == PH_WRITING);
      reading_mask[i] = (phase[i] == PH_READING);
    end
    slot_ok     = (in_slot < SLOT_IN_W'(SLOT_COUNT));
    sel_writing = |(sel & writing_mask);
    sel_reading = |(sel & reading_mask);
    wp_empty    = |(wp_sel & empty_mask);
    slot_idx    = in_slot[SLOT_W-1:0];
  end

  always_comb begin
    ready_pad = '0;
    for (int l = 0; l <= LEVELS; l++) begin
      for (int j = 0; j < PAD; j++) begin
        lv_valid[l][j] = 1'b0;
        lv_frame[l][j] = '0;
        lv_idx[l][j]   = '0;
      end
    end
    for (int j = 0; j < SLOT_COUNT; j++) begin
      ready_pad[j]   = (phase[j] == PH_READY);
      lv_frame[0][j] = frame_num[j];
    end
    for (int j = 0; j < PAD; j++) begin
      lv_valid[0][j] = ready_pad[j];
      lv_idx[0][j]   = SLOT_W'(j);
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int k = 0; k < (PAD >> (l + 1)); k++) begin
        if (lv_valid[l][2*k+1] &&
            (!lv_valid[l][2*k] || (lv_frame[l][2*k+1] < lv_frame[l][2*k]))) begin
          lv_valid[l+1][k] = 1'b1;
          lv_frame[l+1][k] = lv_frame[l][2*k+1];
          lv_idx[l+1][k]   = lv_idx[l][2*k+1];
        end else begin
          lv_valid[l+1][k] = lv_valid[l][2*k];
          lv_frame[l+1][k] = lv_frame[l][2*k];
          lv_idx[l+1][k]   = lv_idx[l][2*k];
        end
      end
    end
    best_valid = lv_valid[LEVELS][0];
    best_frame = lv_frame[LEVELS][0];
    best_idx   = lv_idx[LEVELS][0];
  end

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      phase_next[i] = phase[i];
    end
    wp_next    = wp;
    frame_we   = 1'b0;
    res_status = ST_REFUSED;
    res_slot   = '0;
    res_frame  = '0;
    unique case (in_op)
      OP_ACQ_WRITE: begin
        if (wp_empty) begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (wp_sel[i]) phase_next[i] = PH_WRITING;
          end
          res_status = ST_DONE;
          res_slot   = SLOT_OUT_W'(wp);
        end
      end
      OP_PUBLISH: begin
        if (slot_ok && sel_writing) begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (sel[i]) phase_next[i] = PH_READY;
          end
          frame_we   = 1'b1;
          wp_next    = (slot_idx == SLOT_W'(SLOT_COUNT - 1)) ? '0 : slot_idx + SLOT_W'(1);
          res_status = ST_DONE;
        end
      end
      OP_CANCEL: begin
        if (slot_ok && sel_writing) begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (sel[i]) phase_next[i] = PH_EMPTY;
          end
          res_status = ST_DONE;
        end
      end
      OP_ACQ_READ: begin
        if (best_valid) begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (best_sel[i]) phase_next[i] = PH_READING;
          end
          res_status = ST_DONE;
          res_slot   = SLOT_OUT_W'(best_idx);
          res_frame  = best_frame;
        end
      end
      OP_RELEASE: begin
        if (slot_ok && sel_reading) begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (sel[i]) phase_next[i] = PH_EMPTY;
          end
          res_status = ST_DONE;
        end
      end
      default: begin
        res_status = ST_REFUSED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        phase[i] <= PH_EMPTY;
      end
      wp <= '0;
    end else if (advance) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        phase[i] <= phase_next[i];
      end
      wp <= wp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && frame_we) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (sel[i]) frame_num[i] <= in_frame;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {(OUT_TDATA_W - OUT_FIELDS_W)'(0), res_frame, res_slot, res_status};
    end
  end

endmodule

`default_nettype wire

### src/fshm_checker.sv
// ----------------------------------------------------------------------------
// Frame slot handoff manager checker
// Port-level assertions on the core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_slot_handoff_manager_core_macros.svh"

module fshm_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tvalid,
  input wire logic                             s_tready,
  // opcode[2:0], slot[10:3], frame_number[42:11], zero fill
  input wire logic [fshm_pkg::IN_TDATA_W-1:0]  s_tdata,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  // status[0], slot_out[4:1], frame_out[36:5], zero fill
  input wire logic [fshm_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import fshm_pkg::*;

  logic refused;
  logic [SLOT_OUT_W+FRAME_W-1:0] grant_fields;

  assign refused      = m_tdata[0] == ST_REFUSED;
  assign grant_fields = m_tdata[STATUS_W +: SLOT_OUT_W + FRAME_W];

  `FSHM_ASSERT_NEXT(a_result_holds, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `FSHM_ASSERT_IMPL(a_refused_zero, clk, rst, m_tvalid && refused, grant_fields == '0)
  `FSHM_ASSERT_IMPL(a_stall_only_full, clk, rst, !s_tready, m_tvalid)
  `FSHM_ASSERT_IMPL(a_no_result_after_reset, clk, rst, $past(rst), !m_tvalid)

endmodule

bind frame_slot_handoff_manager_core fshm_checker u_fshm_checker (.*);

`default_nettype wire
